// ===== rtl/console_line_editor_unit_assert.svh =====
// Assertion macros shared by the console line editor modules.
`ifndef CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("console line editor: assertion failed");

// Next-cycle implication, checked out of reset.
`define CLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("console line editor: assertion failed");

`endif

// ===== rtl/cle_pkg.sv =====
`default_nettype none

package cle_pkg;

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [5:0] LIMIT_RESET = 6'd32;

    typedef enum logic [1:0] {
        OP_BS,
        OP_CR,
        OP_CHAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       store;
        logic       flush;
        logic [5:0] addr;
        logic [5:0] len;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/console_line_editor_unit.sv =====
// Path: a byte transfer enters the command queue, the back takes it into its command register and
// loads each echo result into the output register, where a result waits until it is taken;
// a flushed line adds a store read, then an output, per stored character, and a line end result.
// The front takes a byte every cycle while the 2-entry command queue has room.
// Reset (aresetn low, synchronous): fill count 0, limit 32, queue and output empty;
// the line store is not cleared.
`default_nettype none

module console_line_editor_unit #(
    parameter int MAX_LINE = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_data_byte,
    output logic [5:0]      m_line_length,
    output logic            m_last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_line_limit
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    cle_pkg::cmd_t q_in;
    cle_pkg::cmd_t q_out;

    cle_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_line_limit (cfg_line_limit),
        .q_push         (q_push),
        .q_data         (q_in),
        .q_full         (q_full)
    );

    cle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    cle_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_line_length (m_line_length),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/cle_ram.sv =====
`default_nettype none

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cle_queue.sv =====
`default_nettype none

module cle_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire cle_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output cle_pkg::cmd_t      pop_data,
    output logic               empty
);

    cle_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                entry_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg            <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cle_front.sv =====
`default_nettype none

module cle_front #(
    parameter int MAX_LINE = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [5:0]    cfg_line_limit,
    output logic               q_push,
    output cle_pkg::cmd_t      q_data,
    input  wire logic          q_full
);

    `include "console_line_editor_unit_assert.svh"

    localparam int CW = $clog2(MAX_LINE + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [5:0]    limit_reg;
    logic [6:0]    eff_limit;
    logic          stored;
    logic [CW-1:0] grown;
    logic          accept;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    always_comb begin
        if (limit_reg == 6'd0) begin
            eff_limit = 7'd1;
        end else if ({1'b0, limit_reg} > 7'(MAX_LINE)) begin
            eff_limit = 7'(MAX_LINE);
        end else begin
            eff_limit = {1'b0, limit_reg};
        end
    end

    assign stored = (count_reg < CW'(MAX_LINE));
    assign grown  = count_reg + {{(CW-1){1'b0}}, stored};

    always_comb begin
        q_data.op    = cle_pkg::OP_CHAR;
        q_data.data  = s_rx_byte;
        q_data.store = 1'b0;
        q_data.flush = 1'b0;
        q_data.addr  = 6'(count_reg);
        q_data.len   = 6'(count_reg);
        q_push       = 1'b0;
        count_next   = count_reg;
        case (s_rx_byte)
            cle_pkg::CH_BS: begin
                q_data.op = cle_pkg::OP_BS;
                if (count_reg != '0) begin
                    q_push     = accept;
                    count_next = count_reg - {{(CW-1){1'b0}}, 1'b1};
                end
            end
            cle_pkg::CH_CR: begin
                q_data.op  = cle_pkg::OP_CR;
                q_push     = accept;
                count_next = '0;
            end
            default: begin
                q_data.store = stored;
                q_data.flush = (7'(grown) >= eff_limit);
                q_data.len   = 6'(grown);
                q_push       = accept;
                count_next   = q_data.flush ? '0 : grown;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            limit_reg <= cle_pkg::LIMIT_RESET;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (cfg_valid) begin
                limit_reg <= cfg_line_limit;
            end
        end
    end

    `CLE_ASSERT_IMPL(a_count_below_store, 1'b1, count_reg < CW'(MAX_LINE))
    `CLE_ASSERT_IMPL(a_bs_drop_only_empty, accept && !q_push, count_reg == '0)

endmodule

`default_nettype wire

// ===== rtl/cle_back.sv =====
`default_nettype none

module cle_back #(
    parameter int MAX_LINE = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  wire cle_pkg::cmd_t q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_kind,
    output logic [7:0]         m_data_byte,
    output logic [5:0]         m_line_length,
    output logic               m_last
);

    `include "console_line_editor_unit_assert.svh"

    localparam int AW = $clog2(MAX_LINE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_RD,
        ST_CH,
        ST_END
    } state_t;

    state_t        state_reg;
    cle_pkg::cmd_t cmd_reg;
    logic [1:0]    step_reg;
    logic [5:0]    idx_reg;
    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [7:0]    m_data_reg;
    logic [5:0]    m_len_reg;
    logic          m_last_reg;

    logic          out_free;
    logic          out_load;
    logic [7:0]    echo_byte;
    logic          echo_final;
    logic          do_flush;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [7:0]    ram_rd_data;

    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = out_free && (state_reg inside {ST_ECHO, ST_CH, ST_END});
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign ram_wr_en = q_pop && (q_data.op == cle_pkg::OP_CHAR) && q_data.store;
    assign ram_rd_en = (state_reg == ST_RD);
    assign do_flush  = (cmd_reg.op == cle_pkg::OP_CR)
                    || ((cmd_reg.op == cle_pkg::OP_CHAR) && cmd_reg.flush);

    always_comb begin
        case (cmd_reg.op)
            cle_pkg::OP_BS: begin
                echo_byte  = (step_reg == 2'd1) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
                echo_final = (step_reg == 2'd2);
            end
            cle_pkg::OP_CR: begin
                echo_byte  = cle_pkg::CH_CR;
                echo_final = 1'b1;
            end
            default: begin
                echo_byte  = (step_reg == 2'd0) ? cmd_reg.data : cle_pkg::CH_CR;
                echo_final = (cmd_reg.data != cle_pkg::CH_LF) || (step_reg == 2'd1);
            end
        endcase
    end

    cle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (q_data.addr[AW-1:0]),
        .wr_data (q_data.data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        cmd_reg   <= q_data;
                        step_reg  <= 2'd0;
                        state_reg <= ST_ECHO;
                    end
                end
                ST_ECHO: begin
                    if (out_free) begin
                        m_kind_reg  <= cle_pkg::KIND_ECHO;
                        m_data_reg  <= echo_byte;
                        m_len_reg   <= 6'd0;
                        m_last_reg  <= echo_final && !do_flush;
                        if (echo_final) begin
                            idx_reg <= 6'd0;
                            if (!do_flush) begin
                                state_reg <= ST_IDLE;
                            end else if (cmd_reg.len == 6'd0) begin
                                state_reg <= ST_END;
                            end else begin
                                state_reg <= ST_RD;
                            end
                        end else begin
                            step_reg <= step_reg + 2'd1;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_CH;
                end
                ST_CH: begin
                    if (out_free) begin
                        m_kind_reg  <= cle_pkg::KIND_CHAR;
                        m_data_reg  <= ram_rd_data;
                        m_len_reg   <= 6'd0;
                        m_last_reg  <= 1'b0;
                        idx_reg     <= idx_reg + 6'd1;
                        state_reg   <= ((idx_reg + 6'd1) == cmd_reg.len) ? ST_END : ST_RD;
                    end
                end
                ST_END: begin
                    if (out_free) begin
                        m_kind_reg  <= cle_pkg::KIND_END;
                        m_data_reg  <= cle_pkg::CH_NUL;
                        m_len_reg   <= cmd_reg.len;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_data_byte   = m_data_reg;
    assign m_line_length = m_len_reg;
    assign m_last        = m_last_reg;

    `CLE_ASSERT_IMPL(a_end_is_last, m_valid_reg && (m_kind_reg == cle_pkg::KIND_END), m_last_reg)
    `CLE_ASSERT_IMPL(a_read_in_line, state_reg == ST_CH, idx_reg < cmd_reg.len)
    `CLE_ASSERT_NEXT(a_pop_to_echo, q_pop, state_reg == ST_ECHO)

endmodule

`default_nettype wire
